/* src/smudge_patch_blend_assert.svh */
// Assertion macros shared by the smudge patch blender RTL.
`ifndef SMUDGE_PATCH_BLEND_ASSERT_SVH
`define SMUDGE_PATCH_BLEND_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SPB_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SPB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/spb_pkg.sv */
// Types and constants of the smudge patch blender.
package spb_pkg;

    localparam int CHAN_W = 8;
    localparam int POS_W  = 5;
    localparam int MASK_W = 16;
    // opacity * mask + rounding term
    localparam int X_W    = 24;

    localparam logic [CHAN_W-1:0] OPACITY_RESET = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE  = 8'd255;
    localparam logic [X_W-1:0]    ROUND_255     = 24'd127;

    // floor(x / 255) = (x * RECIP_255) >> RECIP_SHIFT, exact for x < 2^24
    localparam int                RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP_255  = 25'h1010102;
    localparam int                RECIP_SHIFT = 32;

    typedef enum logic {
        OP_PICKUP = 1'b0,
        OP_SMUDGE = 1'b1
    } op_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        op_t               operation;
        logic [POS_W-1:0]  window_row;
        logic [POS_W-1:0]  window_col;
        logic              on_canvas;
        logic [CHAN_W-1:0] pixel_red;
        logic [CHAN_W-1:0] pixel_green;
        logic [CHAN_W-1:0] pixel_blue;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_col;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } out_item_t;

endpackage

/* src/spb_store.sv */
// Patch store RAM and mask ROM, both with registered read data.
module spb_store #(
    parameter int RADIUS = 8
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0] rd_addr,
    output spb_pkg::rgb_t                 rd_patch,
    output logic [spb_pkg::MASK_W-1:0]    rd_mask,
    input  logic                          wr_en,
    input  logic [$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0] wr_addr,
    input  spb_pkg::rgb_t                 wr_data
);

    localparam int DIAM  = 2 * RADIUS + 1;
    localparam int CELLS = DIAM * DIAM;

    typedef logic [spb_pkg::MASK_W-1:0] mask_rom_t [CELLS];

    // Quadratic falloff (1 - d/R)^2 in Q0.16, rounded, saturated at the centre
    function automatic logic [spb_pkg::MASK_W-1:0] mask_value(input int dr, input int dc);
        logic [63:0] s;
        logic [63:0] rr;
        logic [63:0] v;
        logic [63:0] root;
        logic [63:0] bit_m;
        logic [63:0] t;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] rem;
        int          i;
        s  = 64'(dr * dr + dc * dc);
        rr = 64'(RADIUS * RADIUS);
        if (s >= rr) begin
            return '0;
        end
        // integer square root of s * 2^32 gives the distance in Q16
        v     = s << 32;
        root  = '0;
        bit_m = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (v >= root + bit_m) begin
                v    = v - (root + bit_m);
                root = (root >> 1) + bit_m;
            end else begin
                root = root >> 1;
            end
            bit_m = bit_m >> 2;
        end
        t   = (64'(RADIUS) << 16) - root;
        num = t * t + (rr << 15);
        den = rr << 16;
        // restoring division, evaluated at elaboration
        quo = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        if (quo > 64'd65535) begin
            return '1;
        end
        return quo[spb_pkg::MASK_W-1:0];
    endfunction

    function automatic mask_rom_t build_mask_rom();
        mask_rom_t rom;
        int        r;
        int        c;
        for (r = 0; r < DIAM; r++) begin
            for (c = 0; c < DIAM; c++) begin
                rom[r * DIAM + c] = mask_value(r - RADIUS, c - RADIUS);
            end
        end
        return rom;
    endfunction

    localparam mask_rom_t MASK_ROM = build_mask_rom();

    spb_pkg::rgb_t patch_mem [CELLS];

    // Write the patch entry; a read of the same entry in that cycle sees the old value
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            patch_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_patch <= patch_mem[rd_addr];
        end
    end

    // Read the mask ROM
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_mask <= MASK_ROM[rd_addr];
        end
    end

endmodule

/* src/smudge_patch_blend.sv */
// Smudge brush patch blender: takes one window pixel per cycle at full rate. An item passes
// four stages (store read, opacity times mask, divide by 255, blend); its result is driven
// from the last stage's register. The patch store has one read and one write port; each
// item reads its entry on acceptance and writes it back when it leaves the last stage, and
// younger items with the same entry pick up that write by forwarding, so back-to-back hits
// on one entry keep the full rate. A stalled result holds the last stage; earlier stages keep
// filling, and input is refused only when all four stages are full. Pick-up and off-canvas
// items give no result; positions outside the window are dropped. Patch entries must be
// picked up before they are smudged. There is no clearing pass after reset.
module smudge_patch_blend #(
    parameter int RADIUS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  spb_pkg::in_item_t         s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output spb_pkg::out_item_t        m_item,
    input  logic                      cfg_wr_en,
    input  logic [spb_pkg::CHAN_W-1:0] cfg_wr_data
);

`include "smudge_patch_blend_assert.svh"

    localparam int DIAM  = 2 * RADIUS + 1;
    localparam int CELLS = DIAM * DIAM;
    localparam int IDX_W = $clog2(CELLS);
    localparam int PROD_W = spb_pkg::X_W + spb_pkg::RECIP_W;

    // Blend one channel: (old * (1 - w) + patch * w) >> 16, truncated
    function automatic logic [spb_pkg::CHAN_W-1:0] blend_chan(
        input logic [spb_pkg::CHAN_W-1:0] old_val,
        input logic [spb_pkg::CHAN_W-1:0] pat_val,
        input logic [spb_pkg::MASK_W-1:0] w16
    );
        logic [spb_pkg::MASK_W:0]   inv;
        logic [spb_pkg::MASK_W+8:0] acc;
        inv = (17'd1 << spb_pkg::MASK_W) - {1'b0, w16};
        acc = 25'(old_val) * 25'(inv) + 25'(pat_val) * 25'(w16);
        return acc[spb_pkg::MASK_W +: spb_pkg::CHAN_W];
    endfunction

    logic [spb_pkg::CHAN_W-1:0] opacity_reg;

    // Input decode
    logic                in_range;
    logic [IDX_W-1:0]    in_idx;
    logic                in_smudge;
    spb_pkg::rgb_t       in_pix;
    logic                accept;
    logic                enter;

    // Pipeline stage registers
    logic                      p1_valid_reg, p1_valid_next;
    logic                      p1_smudge_reg;
    logic [spb_pkg::POS_W-1:0] p1_row_reg, p1_col_reg;
    logic [IDX_W-1:0]          p1_idx_reg;
    spb_pkg::rgb_t             p1_pix_reg, p1_patch_reg;
    logic                      p1_use_mem_reg;

    logic                      p2_valid_reg, p2_valid_next;
    logic                      p2_smudge_reg;
    logic [spb_pkg::POS_W-1:0] p2_row_reg, p2_col_reg;
    logic [IDX_W-1:0]          p2_idx_reg;
    spb_pkg::rgb_t             p2_pix_reg, p2_patch_reg;
    logic [spb_pkg::X_W-1:0]   p2_x_reg;

    logic                      p3_valid_reg, p3_valid_next;
    logic                      p3_smudge_reg;
    logic [spb_pkg::POS_W-1:0] p3_row_reg, p3_col_reg;
    logic [IDX_W-1:0]          p3_idx_reg;
    spb_pkg::rgb_t             p3_pix_reg, p3_patch_reg;
    logic [spb_pkg::MASK_W-1:0] p3_w16_reg;

    logic                      p4_valid_reg, p4_valid_next;
    logic                      p4_smudge_reg;
    logic [spb_pkg::POS_W-1:0] p4_row_reg, p4_col_reg;
    logic [IDX_W-1:0]          p4_idx_reg;
    spb_pkg::rgb_t             p4_rgb_reg;

    // Flow control
    logic leave4, move3, move2, move1;

    // Store ports and forwarding
    spb_pkg::rgb_t              rd_patch;
    logic [spb_pkg::MASK_W-1:0] rd_mask;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    spb_pkg::rgb_t              wr_data;
    spb_pkg::rgb_t              p1_fwd, p2_fwd, p3_fwd;
    logic [PROD_W-1:0]          recip_prod;
    spb_pkg::rgb_t              blend_rgb;

    // Hold the opacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opacity_reg <= spb_pkg::OPACITY_RESET;
        end else if (cfg_wr_en) begin
            opacity_reg <= cfg_wr_data;
        end
    end

    // Decode the incoming item
    always_comb begin
        in_range  = (int'(s_item.window_row) < DIAM) && (int'(s_item.window_col) < DIAM);
        in_idx    = IDX_W'(int'(s_item.window_row) * DIAM + int'(s_item.window_col));
        in_smudge = s_item.on_canvas && (s_item.operation == spb_pkg::OP_SMUDGE);
        if (s_item.on_canvas) begin
            in_pix = '{red: s_item.pixel_red, green: s_item.pixel_green,
                       blue: s_item.pixel_blue};
        end else begin
            in_pix = '0;
        end
    end

    // Advance each stage when the one after it is empty or moving on
    always_comb begin
        leave4  = p4_valid_reg && (!p4_smudge_reg || m_ready);
        move3   = p3_valid_reg && (!p4_valid_reg || leave4);
        move2   = p2_valid_reg && (!p3_valid_reg || move3);
        move1   = p1_valid_reg && (!p2_valid_reg || move2);
        s_ready = !p1_valid_reg || move1;
        accept  = s_valid && s_ready;
        enter   = accept && in_range;
    end

    // Write back the patch entry as the item leaves the last stage
    assign wr_en   = leave4;
    assign wr_addr = p4_idx_reg;
    assign wr_data = p4_rgb_reg;

    spb_store #(
        .RADIUS (RADIUS)
    ) u_store (
        .aclk     (aclk),
        .rd_en    (enter),
        .rd_addr  (in_idx),
        .rd_patch (rd_patch),
        .rd_mask  (rd_mask),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    // Forward the write-back into younger items on the same entry
    always_comb begin
        p1_fwd = p1_use_mem_reg ? rd_patch : p1_patch_reg;
        if (wr_en && (wr_addr == p1_idx_reg)) begin
            p1_fwd = wr_data;
        end
        p2_fwd = (wr_en && (wr_addr == p2_idx_reg)) ? wr_data : p2_patch_reg;
        p3_fwd = (wr_en && (wr_addr == p3_idx_reg)) ? wr_data : p3_patch_reg;
    end

    // Divide by 255 through the reciprocal
    assign recip_prod = PROD_W'(p2_x_reg) * PROD_W'(spb_pkg::RECIP_255);

    // Blend the canvas pixel toward the patch colour
    always_comb begin
        blend_rgb.red   = blend_chan(p3_pix_reg.red,   p3_fwd.red,   p3_w16_reg);
        blend_rgb.green = blend_chan(p3_pix_reg.green, p3_fwd.green, p3_w16_reg);
        blend_rgb.blue  = blend_chan(p3_pix_reg.blue,  p3_fwd.blue,  p3_w16_reg);
    end

    // Stage valid bits
    always_comb begin
        p1_valid_next = enter ? 1'b1 : (move1 ? 1'b0 : p1_valid_reg);
        p2_valid_next = move1 ? 1'b1 : (move2 ? 1'b0 : p2_valid_reg);
        p3_valid_next = move2 ? 1'b1 : (move3 ? 1'b0 : p3_valid_reg);
        p4_valid_next = move3 ? 1'b1 : (leave4 ? 1'b0 : p4_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            p3_valid_reg <= p3_valid_next;
            p4_valid_reg <= p4_valid_next;
        end
    end

    // Stage 1: capture the item; note a write to its entry in the read cycle
    always_ff @(posedge aclk) begin
        if (enter) begin
            p1_smudge_reg  <= in_smudge;
            p1_row_reg     <= s_item.window_row;
            p1_col_reg     <= s_item.window_col;
            p1_idx_reg     <= in_idx;
            p1_pix_reg     <= in_pix;
            p1_use_mem_reg <= !(wr_en && (wr_addr == in_idx));
            p1_patch_reg   <= wr_data;
        end else if (!move1) begin
            p1_use_mem_reg <= 1'b0;
            p1_patch_reg   <= p1_fwd;
        end
    end

    // Stage 2: scale the mask by opacity
    always_ff @(posedge aclk) begin
        if (move1) begin
            p2_smudge_reg <= p1_smudge_reg;
            p2_row_reg    <= p1_row_reg;
            p2_col_reg    <= p1_col_reg;
            p2_idx_reg    <= p1_idx_reg;
            p2_pix_reg    <= p1_pix_reg;
            p2_patch_reg  <= p1_fwd;
            p2_x_reg      <= spb_pkg::X_W'(opacity_reg) * spb_pkg::X_W'(rd_mask)
                             + spb_pkg::ROUND_255;
        end else if (!move2) begin
            p2_patch_reg  <= p2_fwd;
        end
    end

    // Stage 3: blend weight
    always_ff @(posedge aclk) begin
        if (move2) begin
            p3_smudge_reg <= p2_smudge_reg;
            p3_row_reg    <= p2_row_reg;
            p3_col_reg    <= p2_col_reg;
            p3_idx_reg    <= p2_idx_reg;
            p3_pix_reg    <= p2_pix_reg;
            p3_patch_reg  <= p2_fwd;
            p3_w16_reg    <= recip_prod[spb_pkg::RECIP_SHIFT +: spb_pkg::MASK_W];
        end else if (!move3) begin
            p3_patch_reg  <= p3_fwd;
        end
    end

    // Stage 4: result and write-back data
    always_ff @(posedge aclk) begin
        if (move3) begin
            p4_smudge_reg <= p3_smudge_reg;
            p4_row_reg    <= p3_row_reg;
            p4_col_reg    <= p3_col_reg;
            p4_idx_reg    <= p3_idx_reg;
            p4_rgb_reg    <= p3_smudge_reg ? blend_rgb : p3_pix_reg;
        end
    end

    // Drive the result channel
    assign m_valid = p4_valid_reg && p4_smudge_reg;
    always_comb begin
        m_item.out_row   = p4_row_reg;
        m_item.out_col   = p4_col_reg;
        m_item.out_red   = p4_rgb_reg.red;
        m_item.out_green = p4_rgb_reg.green;
        m_item.out_blue  = p4_rgb_reg.blue;
        m_item.out_alpha = spb_pkg::ALPHA_OPAQUE;
    end

    // Input is refused only with every stage occupied
    `SPB_ASSERT_SAME(a_full_when_refused, aclk, aresetn, !s_ready, (p1_valid_reg && p2_valid_reg && p3_valid_reg && p4_valid_reg), "input refused with a free stage")
    // An accepted in-window item occupies stage 1 next cycle
    `SPB_ASSERT_NEXT(a_enter_fills_p1, aclk, aresetn, enter, p1_valid_reg, "accepted item lost before stage 1")
    // Write-back stays inside the patch store
    `SPB_ASSERT_SAME(a_wr_in_range, aclk, aresetn, wr_en, (int'(wr_addr) < CELLS), "patch write outside the window")
    // A delivered result is written back in the same cycle
    `SPB_ASSERT_SAME(a_result_written, aclk, aresetn, (m_valid && m_ready), (wr_en && (wr_data == p4_rgb_reg)), "result delivered without write-back")

endmodule

/* dv/tb_smudge_patch_blend.sv */
// Self-checking testbench for the smudge patch blender: directed table plus random strokes.
`timescale 1ns / 100ps

module tb_smudge_patch_blend;

    localparam int WIN_RADIUS  = 8;
    localparam int WIN_SIDE    = 2 * WIN_RADIUS + 1;
    localparam int WIN_CELLS   = WIN_SIDE * WIN_SIDE;
    // four pipeline stages plus margin
    localparam int PIPE_SETTLE = 8;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 295;

    typedef struct packed {
        bit                 cfg_write;
        logic [7:0]         opacity;
        spb_pkg::in_item_t  item;
        bit                 fixed;
        logic [23:0]        want_rgb;
    } pattern_row_t;

    typedef struct packed {
        bit                 fixed;
        spb_pkg::out_item_t want;
    } typed_result_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    spb_pkg::in_item_t  s_item      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    spb_pkg::out_item_t m_item;
    logic               cfg_wr_en   = 1'b0;
    logic [7:0]         cfg_wr_data = '0;

    // predictor state
    int unsigned   weight_rom [0:WIN_CELLS-1];
    spb_pkg::rgb_t patch_rgb  [0:WIN_CELLS-1];
    logic [7:0]    cur_opacity = spb_pkg::OPACITY_RESET;
    bit            entry_filled [0:WIN_CELLS-1];

    spb_pkg::out_item_t blend_q[$];
    typed_result_t      typed_q[$];
    pattern_row_t       directed_rows[$];

    int unsigned   feed_idle_pct  = 0;
    int unsigned   sink_stall_pct = 0;
    int unsigned   errors         = 0;
    int unsigned   checked        = 0;
    int unsigned   items_sent     = 0;
    int unsigned   items_dropped  = 0;
    int unsigned   opacity_writes = 0;

    smudge_patch_blend #(
        .RADIUS (WIN_RADIUS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Quadratic falloff weight in Q0.16 for an offset from the window centre.
    function automatic int unsigned falloff_weight(input int dr, input int dc);
        longint unsigned dist2, rr, scaled, root, trial, t, m;
        dist2 = longint'(dr * dr + dc * dc);
        rr    = WIN_RADIUS * WIN_RADIUS;
        if (dist2 >= rr) return 0;
        // distance in Q16: integer square root, one bit at a time
        scaled = dist2 << 32;
        root   = 0;
        for (int b = 23; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= scaled) root = trial;
        end
        t = (longint'(WIN_RADIUS) << 16) - root;
        m = (t * t + (rr << 15)) / (rr << 16);
        if (m > 65535) m = 65535;
        return int'(m);
    endfunction

    function automatic logic [7:0] mix_channel(input logic [7:0] old, input logic [7:0] pat,
                                               input int unsigned w16);
        longint unsigned acc;
        acc = longint'(old) * (65536 - w16) + longint'(pat) * w16;
        return 8'(acc >> 16);
    endfunction

    // Apply one accepted item to the patch store; report the blended pixel if any.
    function automatic void predict_blend(input spb_pkg::in_item_t it, output bit makes_pixel,
                                          output spb_pkg::out_item_t px);
        int unsigned   idx, w16;
        spb_pkg::rgb_t held;
        makes_pixel = 1'b0;
        px          = '0;
        if (it.window_row >= WIN_SIDE || it.window_col >= WIN_SIDE) return;
        idx = it.window_row * WIN_SIDE + it.window_col;
        if (!it.on_canvas) begin
            patch_rgb[idx] = '0;
            return;
        end
        if (it.operation == spb_pkg::OP_PICKUP) begin
            patch_rgb[idx].red   = it.pixel_red;
            patch_rgb[idx].green = it.pixel_green;
            patch_rgb[idx].blue  = it.pixel_blue;
            return;
        end
        held = patch_rgb[idx];
        w16  = (cur_opacity * weight_rom[idx] + 127) / 255;
        px.out_row   = it.window_row;
        px.out_col   = it.window_col;
        px.out_red   = mix_channel(it.pixel_red,   held.red,   w16);
        px.out_green = mix_channel(it.pixel_green, held.green, w16);
        px.out_blue  = mix_channel(it.pixel_blue,  held.blue,  w16);
        px.out_alpha = spb_pkg::ALPHA_OPAQUE;
        patch_rgb[idx].red   = px.out_red;
        patch_rgb[idx].green = px.out_green;
        patch_rgb[idx].blue  = px.out_blue;
        makes_pixel = 1'b1;
    endfunction

    // Track which entries hold defined paint, so no smudge reads an unwritten entry.
    function automatic void note_store_write(input spb_pkg::in_item_t it);
        if (it.window_row < WIN_SIDE && it.window_col < WIN_SIDE &&
                (!it.on_canvas || it.operation == spb_pkg::OP_PICKUP)) begin
            entry_filled[it.window_row * WIN_SIDE + it.window_col] = 1'b1;
        end
    endfunction

    function automatic logic [7:0] pick_level();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12) return 8'h00;
        if (roll < 24) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic add_row(input spb_pkg::op_t op, input int rw, input int cl, input bit onc,
                           input logic [23:0] rgb, input bit fixed, input logic [23:0] want);
        pattern_row_t r;
        r                  = '0;
        r.item.operation   = op;
        r.item.window_row  = 5'(rw);
        r.item.window_col  = 5'(cl);
        r.item.on_canvas   = onc;
        r.item.pixel_red   = rgb[23:16];
        r.item.pixel_green = rgb[15:8];
        r.item.pixel_blue  = rgb[7:0];
        r.fixed            = fixed;
        r.want_rgb         = want;
        directed_rows.push_back(r);
    endtask

    task automatic add_opacity(input logic [7:0] value);
        pattern_row_t r;
        r           = '0;
        r.cfg_write = 1'b1;
        r.opacity   = value;
        directed_rows.push_back(r);
    endtask

    // Drop valid and hold until the pipeline has emptied.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (blend_q.size() != 0) @(negedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    task automatic set_opacity(input logic [7:0] value);
        hold_until_drained();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        opacity_writes++;
    endtask

    // Present one item after random idle cycles; return at the falling edge after acceptance.
    task automatic send_item(input spb_pkg::in_item_t it);
        while ($urandom_range(99) < feed_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Stall the result channel at random.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Predict on each accepted item, check each accepted result.
    always @(posedge aclk) begin : scoreboard
        spb_pkg::out_item_t want;
        spb_pkg::out_item_t got;
        bit                 makes_pixel;
        typed_result_t      typed;
        if (!aresetn) begin
            cur_opacity = spb_pkg::OPACITY_RESET;
        end else begin
            if (m_valid && m_ready) begin
                got = m_item;
                if (blend_q.size() == 0) begin
                    $error("unexpected blended pixel at row %0d col %0d",
                           got.out_row, got.out_col);
                    errors++;
                end else begin
                    want = blend_q.pop_front();
                    checked++;
                    if (got.out_row !== want.out_row) begin
                        $error("out_row expected %0d got %0d", want.out_row, got.out_row);
                        errors++;
                    end
                    if (got.out_col !== want.out_col) begin
                        $error("out_col expected %0d got %0d", want.out_col, got.out_col);
                        errors++;
                    end
                    if (got.out_red !== want.out_red) begin
                        $error("out_red expected %0d got %0d", want.out_red, got.out_red);
                        errors++;
                    end
                    if (got.out_green !== want.out_green) begin
                        $error("out_green expected %0d got %0d", want.out_green, got.out_green);
                        errors++;
                    end
                    if (got.out_blue !== want.out_blue) begin
                        $error("out_blue expected %0d got %0d", want.out_blue, got.out_blue);
                        errors++;
                    end
                    if (got.out_alpha !== want.out_alpha) begin
                        $error("out_alpha expected %0d got %0d", want.out_alpha, got.out_alpha);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) cur_opacity = cfg_wr_data;
            if (s_valid && s_ready) begin
                predict_blend(s_item, makes_pixel, want);
                // directed rows may carry a fixed expected value
                if (typed_q.size() != 0) begin
                    typed = typed_q.pop_front();
                    if (typed.fixed) begin
                        want        = typed.want;
                        makes_pixel = 1'b1;
                    end
                end
                if (makes_pixel) blend_q.push_back(want);
            end
        end
    end

    initial begin
        spb_pkg::in_item_t it;
        pattern_row_t      row;
        typed_result_t     tr;
        int                p, n, rw, cl, idx;
        int                last_row, last_col;
        logic [7:0]        phase_opacity;
        int unsigned       feed_pct [N_PHASES];
        int unsigned       sink_pct [N_PHASES];
        logic [7:0]        opac_set [N_PHASES];

        feed_pct = '{0, 49, 0, 18, 0, 49};
        sink_pct = '{0, 0, 49, 18, 0, 49};
        opac_set = '{8'd255, 8'd0, 8'd1, 8'd254, 8'd128, 8'd77};
        last_row = WIN_RADIUS;
        last_col = WIN_RADIUS;

        for (int r = 0; r < WIN_SIDE; r++) begin
            for (int c = 0; c < WIN_SIDE; c++) begin
                weight_rom[r * WIN_SIDE + c]   = falloff_weight(r - WIN_RADIUS, c - WIN_RADIUS);
                patch_rgb[r * WIN_SIDE + c]    = '0;
                entry_filled[r * WIN_SIDE + c] = 1'b0;
            end
        end

        // Directed table, at reset opacity first.
        // centre weight saturates just below one
        add_row(spb_pkg::OP_PICKUP, 8, 8, 1'b1, 24'h000000, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 8, 8, 1'b1, 24'hFFFFFF, 1'b1, 24'h000000);
        add_row(spb_pkg::OP_PICKUP, 8, 8, 1'b1, 24'hFFFFFF, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 8, 8, 1'b1, 24'h000000, 1'b1, 24'hFEFEFE);
        // corners lie outside the radius: pixel passes unchanged
        add_row(spb_pkg::OP_PICKUP, 0, 0, 1'b1, 24'h123456, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 0, 0, 1'b1, 24'hABCDEF, 1'b1, 24'hABCDEF);
        add_row(spb_pkg::OP_PICKUP, 16, 16, 1'b1, 24'hFF00FF, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 16, 16, 1'b1, 24'h00FF00, 1'b1, 24'h00FF00);
        // off canvas clears the entry, whatever the operation
        add_row(spb_pkg::OP_PICKUP, 8, 7, 1'b1, 24'hFFFFFF, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 8, 7, 1'b0, 24'hA5A5A5, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 8, 7, 1'b1, 24'h808080, 1'b0, '0);
        // exactly on the radius: zero weight; just inside: small weight
        add_row(spb_pkg::OP_PICKUP, 16, 8, 1'b1, 24'h5A3CC3, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 16, 8, 1'b1, 24'h000000, 1'b1, 24'h000000);
        add_row(spb_pkg::OP_PICKUP, 15, 8, 1'b1, 24'hFFFFFF, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 15, 8, 1'b1, 24'h000000, 1'b0, '0);
        add_row(spb_pkg::OP_PICKUP, 0, 16, 1'b0, 24'h777777, 1'b0, '0);
        // positions outside the window are dropped
        add_row(spb_pkg::OP_SMUDGE, 17, 3, 1'b1, 24'h010203, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 31, 31, 1'b1, 24'hFFFFFF, 1'b0, '0);
        add_row(spb_pkg::OP_PICKUP, 5, 20, 1'b1, 24'h99AA55, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 0, 16, 1'b1, 24'h334455, 1'b1, 24'h334455);
        // zero opacity leaves the pixel alone
        add_opacity(8'd0);
        add_row(spb_pkg::OP_SMUDGE, 8, 8, 1'b1, 24'h112233, 1'b1, 24'h112233);
        // half opacity, back-to-back hits on one entry
        add_opacity(8'd128);
        add_row(spb_pkg::OP_PICKUP, 4, 12, 1'b1, 24'hC0F0E0, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 4, 12, 1'b1, 24'h102030, 1'b0, '0);
        add_row(spb_pkg::OP_SMUDGE, 4, 12, 1'b1, 24'hF0E0D0, 1'b0, '0);

        // Hold the synchronous reset, then release it.
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table.
        while (directed_rows.size() != 0) begin
            row = directed_rows.pop_front();
            if (row.cfg_write) begin
                set_opacity(row.opacity);
            end else begin
                tr.fixed          = row.fixed;
                tr.want.out_row   = row.item.window_row;
                tr.want.out_col   = row.item.window_col;
                tr.want.out_red   = row.want_rgb[23:16];
                tr.want.out_green = row.want_rgb[15:8];
                tr.want.out_blue  = row.want_rgb[7:0];
                tr.want.out_alpha = spb_pkg::ALPHA_OPAQUE;
                typed_q.push_back(tr);
                note_store_write(row.item);
                send_item(row.item);
                if (row.item.window_row < WIN_SIDE && row.item.window_col < WIN_SIDE)
                    items_sent++;
                else
                    items_dropped++;
            end
        end

        // Random strokes, one phase per idling and opacity setting.
        for (p = 0; p < N_PHASES; p++) begin
            phase_opacity = (p == N_PHASES - 1) ? 8'($urandom_range(253, 2)) : opac_set[p];
            set_opacity(phase_opacity);
            feed_idle_pct  = feed_pct[p];
            sink_stall_pct = sink_pct[p];
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (p == 4 && n == PHASE_ITEMS / 2) hold_until_drained();
                it = '0;
                if ($urandom_range(99) < 6) begin
                    // noise: a position outside the window
                    it.window_row = 5'($urandom_range(31));
                    it.window_col = 5'($urandom_range(31));
                    if (it.window_row < WIN_SIDE && it.window_col < WIN_SIDE)
                        it.window_col = 5'($urandom_range(31, WIN_SIDE));
                    it.operation = spb_pkg::op_t'($urandom_range(1));
                    it.on_canvas = 1'($urandom_range(1));
                    items_dropped++;
                end else begin
                    // stay on the last position often, so entries see back-to-back hits
                    if ($urandom_range(99) < 35) begin
                        rw = last_row;
                        cl = last_col;
                    end else begin
                        rw = $urandom_range(WIN_SIDE - 1);
                        cl = $urandom_range(WIN_SIDE - 1);
                    end
                    idx = rw * WIN_SIDE + cl;
                    it.window_row = 5'(rw);
                    it.window_col = 5'(cl);
                    it.on_canvas  = ($urandom_range(99) >= 8);
                    it.operation  = (entry_filled[idx] && $urandom_range(99) < 60) ?
                                    spb_pkg::OP_SMUDGE : spb_pkg::OP_PICKUP;
                    last_row = rw;
                    last_col = cl;
                    items_sent++;
                    n++;
                end
                it.pixel_red   = pick_level();
                it.pixel_green = pick_level();
                it.pixel_blue  = pick_level();
                note_store_write(it);
                send_item(it);
            end
        end

        hold_until_drained();

        $display("Sent %0d window items and %0d outside the window, across %0d opacity writes,",
                 items_sent, items_dropped, opacity_writes);
        $display("with sender gaps and result stalls; %0d blended pixels compared, %0d mismatches.",
                 checked, errors);
        if (errors == 0 && blend_q.size() == 0) begin
            $display("tb_smudge_patch_blend: PASS");
        end else begin
            $display("tb_smudge_patch_blend: FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(5_000_000);
        $display("tb_smudge_patch_blend: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/spb_pkg.sv
src/spb_store.sv
src/smudge_patch_blend.sv
dv/tb_smudge_patch_blend.sv
